@@ design/stick_channel_normalizer_top_defines.svh @@
// Assertion macros for the stick channel normalizer.
// Used by stick_channel_normalizer_top.sv; expects clk and arst_n in scope.
`ifndef STICK_CHANNEL_NORMALIZER_TOP_DEFINES_SVH
`define STICK_CHANNEL_NORMALIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SCN_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SCN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/scn_pkg.sv @@
// Shared types, constants and helpers of the stick channel normalizer.
// No dependencies; every other .sv design file uses it by scoped names.
`timescale 1ns / 1ps

package scn_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int SAMPLE_BITS  = 12;
	localparam int CH_W         = 2;
	localparam int RAW_W        = 12;
	localparam int BOUND_W      = 16;
	localparam int CFG_W        = 60;
	localparam int QUO_W        = 11;
	localparam int REM_W        = 27;

	localparam logic [QUO_W-1:0] FULL_SCALE  = QUO_W'(2000);
	localparam logic [CFG_W-1:0] MAX_RESET   = 60'h0FFF0FFF0FFF0FFF;

	typedef enum logic [1:0] {
		REG_NORM_ENABLE      = 2'd0,
		REG_CHANNEL_MINIMUMS = 2'd1,
		REG_CHANNEL_MAXIMUMS = 2'd2,
		REG_REVERSE_MASK     = 2'd3
	} scn_reg_t;

	typedef struct packed {
		logic [CH_W-1:0]  channel_index;
		logic [RAW_W-1:0] raw_sample;
	} scn_in_t;

	typedef struct packed {
		logic [CH_W-1:0]  channel_out;
		logic [RAW_W-1:0] degree;
	} scn_out_t;

	typedef struct packed {
		logic             norm_enable;
		logic [CFG_W-1:0] channel_minimums;
		logic [CFG_W-1:0] channel_maximums;
		logic [3:0]       reverse_mask;
	} scn_cfg_t;

	// Per-sample control that rides along the divider chain.
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [RAW_W-1:0] sample;
		logic             bypass;
		logic             empty;
		logic             rev;
	} scn_side_t;

	typedef struct packed {
		scn_side_t          side;
		logic [REM_W-1:0]   rem;
		logic [BOUND_W-1:0] dvs;
		logic [QUO_W-1:0]   quo;
	} scn_div_t;

	// Picks one 16-bit bound out of a packed register; channel 3 has 12 bits.
	function automatic logic [BOUND_W-1:0] bound_of(input logic [CFG_W-1:0] packed_val,
		input logic [CH_W-1:0] ch);
		logic [63:0] wide;
		wide = {4'b0000, packed_val} >> {ch, 4'b0000};
		return wide[BOUND_W-1:0];
	endfunction

endpackage

@@ design/scn_front.sv @@
// Front end of the normalizer: clamp and range setup, then the scale multiply.
// Depends on scn_pkg; feeds the first divider cell.
`timescale 1ns / 1ps

module scn_front #(
	parameter int NUM_CHANNELS = scn_pkg::NUM_CHANNELS,
	parameter int SAMPLE_BITS  = scn_pkg::SAMPLE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scn_pkg::scn_cfg_t cfg,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  scn_pkg::scn_in_t  sample,
	output logic              out_valid,
	input  logic              out_ready,
	output scn_pkg::scn_div_t out_data
);

	localparam logic [scn_pkg::RAW_W-1:0] SAMPLE_MASK = (SAMPLE_BITS >= scn_pkg::RAW_W) ?
		{scn_pkg::RAW_W{1'b1}} : scn_pkg::RAW_W'((1 << SAMPLE_BITS) - 1);

	logic                           v_s1;
	scn_pkg::scn_side_t             side_s1;
	logic [scn_pkg::BOUND_W-1:0]    num_s1;
	logic [scn_pkg::BOUND_W-1:0]    dvs_s1;
	logic                           v_s2;
	scn_pkg::scn_side_t             side_s2;
	logic [scn_pkg::REM_W-1:0]      prod_s2;
	logic [scn_pkg::BOUND_W-1:0]    dvs_s2;
	logic                           rdy_s1;
	logic                           rdy_s2;

	logic [scn_pkg::RAW_W-1:0]      smp;
	logic [scn_pkg::BOUND_W-1:0]    lo;
	logic [scn_pkg::BOUND_W-1:0]    hi;
	logic [scn_pkg::BOUND_W-1:0]    clamp_hi;
	logic [scn_pkg::BOUND_W-1:0]    clamp;
	scn_pkg::scn_side_t             side_d;

	assign rdy_s2       = !v_s2 || out_ready;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign sample_stall = !rdy_s1;

	always_comb begin
		smp      = sample.raw_sample & SAMPLE_MASK;
		lo       = scn_pkg::bound_of(cfg.channel_minimums, sample.channel_index);
		hi       = scn_pkg::bound_of(cfg.channel_maximums, sample.channel_index);
		clamp_hi = (scn_pkg::BOUND_W'(smp) > hi) ? hi : scn_pkg::BOUND_W'(smp);
		clamp    = (clamp_hi < lo) ? lo : clamp_hi;
		side_d.ch     = sample.channel_index;
		side_d.sample = smp;
		side_d.bypass = !cfg.norm_enable ||
			(32'(sample.channel_index) >= 32'(NUM_CHANNELS));
		side_d.empty  = (hi <= lo);
		side_d.rev    = cfg.reverse_mask[sample.channel_index];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= sample_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && sample_valid) begin
			side_s1 <= side_d;
			num_s1  <= clamp - lo;
			dvs_s1  <= hi - lo;
		end
		if (rdy_s2 && v_s1) begin
			side_s2 <= side_s1;
			prod_s2 <= scn_pkg::REM_W'(num_s1) * scn_pkg::REM_W'(scn_pkg::FULL_SCALE);
			dvs_s2  <= dvs_s1;
		end
	end

	always_comb begin
		out_valid     = v_s2;
		out_data.side = side_s2;
		out_data.rem  = prod_s2;
		out_data.dvs  = dvs_s2;
		out_data.quo  = '0;
	end

endmodule

@@ design/scn_div_cell.sv @@
// One cell of the restoring divider chain; settles one quotient bit.
// Depends on scn_pkg; cells are chained in stick_channel_normalizer_top.
`timescale 1ns / 1ps

module scn_div_cell #(
	parameter int BIT = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scn_pkg::scn_div_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output scn_pkg::scn_div_t out_data
);

	logic                      valid_q;
	scn_pkg::scn_div_t         data_q;
	logic [scn_pkg::REM_W-1:0] dvs_shift;
	logic                      take;
	scn_pkg::scn_div_t         data_d;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_comb begin
		dvs_shift = scn_pkg::REM_W'(in_data.dvs) << BIT;
		take      = (in_data.rem >= dvs_shift);
		data_d    = in_data;
		if (take) begin
			data_d.rem      = in_data.rem - dvs_shift;
			data_d.quo[BIT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= data_d;
		end
	end

endmodule

@@ design/stick_channel_normalizer_top.sv @@
// Top level of the stick channel normalizer: config registers, divider chain, result stage.
// Depends on scn_pkg, scn_front, scn_div_cell and stick_channel_normalizer_top_defines.svh.
// Takes one sample per cycle while sample_stall is low; each result passes through the
// clamp stage, multiply stage, eleven divider cells with one quotient bit each, and the
// result register, held there while result_stall is high. Samples with norm_enable low or
// channel_index >= NUM_CHANNELS pass through unchanged; an empty calibration range gives 0.
`timescale 1ns / 1ps
`include "stick_channel_normalizer_top_defines.svh"

module stick_channel_normalizer_top #(
	parameter int NUM_CHANNELS = scn_pkg::NUM_CHANNELS,
	parameter int SAMPLE_BITS  = scn_pkg::SAMPLE_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write_en,
	input  logic [1:0]                cfg_index,
	input  logic [scn_pkg::CFG_W-1:0] cfg_data,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  scn_pkg::scn_in_t          sample,
	output logic                      result_valid,
	input  logic                      result_stall,
	output scn_pkg::scn_out_t         result
);

	localparam int NCELL = scn_pkg::QUO_W;

	scn_pkg::scn_cfg_t  cfg_q;
	logic               div_valid [NCELL+1];
	logic               div_ready [NCELL+1];
	scn_pkg::scn_div_t  div_data  [NCELL+1];

	logic               res_valid_q;
	logic               res_bypass_q;
	scn_pkg::scn_out_t  res_q;
	logic               res_ready;
	scn_pkg::scn_div_t  last;
	logic [scn_pkg::QUO_W-1:0] mag;
	scn_pkg::scn_out_t  res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.norm_enable      <= 1'b0;
			cfg_q.channel_minimums <= '0;
			cfg_q.channel_maximums <= scn_pkg::MAX_RESET;
			cfg_q.reverse_mask     <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				scn_pkg::REG_NORM_ENABLE:      cfg_q.norm_enable      <= cfg_data[0];
				scn_pkg::REG_CHANNEL_MINIMUMS: cfg_q.channel_minimums <= cfg_data;
				scn_pkg::REG_CHANNEL_MAXIMUMS: cfg_q.channel_maximums <= cfg_data;
				scn_pkg::REG_REVERSE_MASK:     cfg_q.reverse_mask     <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	scn_front #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.out_valid    (div_valid[0]),
		.out_ready    (div_ready[0]),
		.out_data     (div_data[0])
	);

	// Cell i settles quotient bit NCELL-1-i, most significant first.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		scn_div_cell #(
			.BIT (NCELL - 1 - i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[i]),
			.in_ready  (div_ready[i]),
			.in_data   (div_data[i]),
			.out_valid (div_valid[i+1]),
			.out_ready (div_ready[i+1]),
			.out_data  (div_data[i+1])
		);
	end

	assign res_ready        = !res_valid_q || !result_stall;
	assign div_ready[NCELL] = res_ready;

	always_comb begin
		last              = div_data[NCELL];
		mag               = last.side.rev ? (scn_pkg::FULL_SCALE - last.quo) : last.quo;
		res_d.channel_out = last.side.ch;
		if (last.side.bypass) begin
			res_d.degree = last.side.sample;
		end else if (last.side.empty) begin
			res_d.degree = '0;
		end else begin
			res_d.degree = scn_pkg::RAW_W'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_ready) begin
			res_valid_q <= div_valid[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && div_valid[NCELL]) begin
			res_q        <= res_d;
			res_bypass_q <= last.side.bypass;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// The input side only waits when a finished result is held back.
	`SCN_ASSERT_IMPL(a_stall_only_when_blocked, sample_stall, result_valid && result_stall, "input stalled without a blocked result")
	`SCN_ASSERT_IMPL(a_degree_in_range, result_valid && !res_bypass_q, result.degree <= scn_pkg::RAW_W'(scn_pkg::FULL_SCALE), "normalized degree above full scale")
	`SCN_ASSERT_IMPL(a_div_remainder, div_valid[NCELL] && !div_data[NCELL].side.empty, div_data[NCELL].rem < scn_pkg::REM_W'(div_data[NCELL].dvs), "divider remainder not below divisor")
	`SCN_ASSERT_NEXT(a_result_drains, result_valid && !result_stall && !div_valid[NCELL], !result_valid, "result register kept a transferred result")

endmodule
